/* sv/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes for the paged frame allocator
// Holds the request and response payloads, the mode and status codes, the
// register map, the sequencer states and the divider handshake structs.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // request modes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_RESIZE = 2'd1;
  localparam logic [1:0] MODE_XLATE  = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  // response status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_EXISTS  = 3'd4;

  // register map (index taken from paddr[2])
  localparam logic REG_PAGE_SIZE   = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  localparam int ADDR_W      = 3;
  localparam int DIVIDEND_W  = 20;
  localparam int DIVISOR_W   = 13;
  localparam int FCOUNT_W    = 7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  process_slot;
    logic [18:0] byte_size;
    logic [5:0]  page_number;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] frame;
    logic [6:0] page_total;
    logic [6:0] frames_free;
  } rsp_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECOUNT,
    S_DECODE,
    S_DIV,
    S_GROW,
    S_SHRINK_RD,
    S_SHRINK_CLR,
    S_XLATE_WAIT,
    S_DONE
  } seq_state_t;

endpackage

/* sv/pfa_divider.sv */
// ----------------------------------------------------------------------------
// pfa_divider: iterative restoring divider
// Produces one quotient bit per cycle; done pulses in the cycle the full
// quotient is available.
// ----------------------------------------------------------------------------
module pfa_divider (
  input  logic              clk,
  input  logic              rst,
  input  pfa_pkg::div_req_t req,
  output pfa_pkg::div_rsp_t rsp
);
  import pfa_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      steps;
  logic [DIVIDEND_W-1:0] acc;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;
  logic                  done;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, acc[DIVIDEND_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      acc <= {acc[DIVIDEND_W-2:0], fits};
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

/* sv/paged_frame_allocator.sv */
// ----------------------------------------------------------------------------
// paged_frame_allocator: frame bitmap and per-process page tables
// Serves create, resize, translate and finish requests against a shared pool
// of physical frames, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_ready/req_valid carries one request; rsp/rsp_valid/rsp_ready
//   returns exactly one response per request. The APB port sets page_size
//   (0x0) and frame_count (0x4); write them only while the block is idle.
//   Create, a zero-byte resize and any error found at decode respond
//   straight from decode; translate adds a page table read. Resize adds a
//   divide for the page count, then a grow scans the bitmap once or a
//   shrink reads and clears each freed page in turn. Finish frees each page
//   held in the same way. A new request is taken the cycle after the
//   previous response is loaded.
//   A frame_count write triggers a recount of free frames, during which
//   req_ready stays low.
//   Reset clears the bitmap, closes all slots and restores the register
//   defaults; the page table memory is not cleared.
//   A stalled response holds in the output register; the next request is
//   accepted and processed, and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module paged_frame_allocator #(
  parameter int MAX_FRAMES    = 64,
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_PAGES     = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  pfa_pkg::req_t          req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output pfa_pkg::rsp_t          rsp,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [pfa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import pfa_pkg::*;

  localparam int FR_W    = $clog2(MAX_FRAMES);
  localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int PG_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SLOT_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int DEPTH   = MAX_PROCESSES * MAX_PAGES;
  localparam int MADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RESET_LIVE = (64 > MAX_FRAMES) ? MAX_FRAMES : 64;

  // configuration
  logic [DIVISOR_W-1:0] page_size;
  logic [FCOUNT_W-1:0]  frame_count;
  logic                 cfg_write;
  logic                 recount_pending;

  // allocator state
  logic [MAX_FRAMES-1:0] frame_used;
  logic [CNT_W-1:0]      page_counts [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] slot_valid;
  logic [FCNT_W-1:0]     free_total;

  // page table memory
  logic [FR_W-1:0]    page_frames [DEPTH];
  logic               mem_we;
  logic [MADDR_W-1:0] mem_waddr;
  logic [MADDR_W-1:0] mem_raddr;
  logic [FR_W-1:0]    mem_rdata;

  // sequencer
  seq_state_t state, state_next;
  req_t             cur;
  logic [CNT_W-1:0] have;
  logic [CNT_W-1:0] need;
  logic [FCNT_W-1:0] ptr;
  logic [FCNT_W-1:0] cnt;
  logic [2:0]       status;
  logic [FR_W-1:0]  frame;

  // derived values
  logic [FCNT_W-1:0]    live;
  logic                 slot_ok;
  logic [SLOT_W-1:0]    idx;
  logic [MADDR_W-1:0]   base;
  logic [CNT_W-1:0]     cur_count;
  logic [DIVISOR_W-1:0] eff_ps;
  logic                 ptr_free;
  logic                 too_big;
  logic                 no_room;
  logic                 grows;
  logic                 out_free;
  logic [FR_W-1:0]      ptr_idx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pfa_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // APB register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAGE_SIZE) begin
      prdata = 32'(page_size);
    end else begin
      prdata = 32'(frame_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size   <= DIVISOR_W'(32);
      frame_count <= FCOUNT_W'(64);
    end else if (cfg_write) begin
      if (paddr[2] == REG_PAGE_SIZE) begin
        page_size <= pwdata[DIVISOR_W-1:0];
      end else begin
        frame_count <= pwdata[FCOUNT_W-1:0];
      end
    end
  end

  // effective frame count and request decode
  always_comb begin
    if (32'(frame_count) > MAX_FRAMES) begin
      live = FCNT_W'(MAX_FRAMES);
    end else begin
      live = FCNT_W'(frame_count);
    end
    eff_ps    = (page_size == '0) ? DIVISOR_W'(1) : page_size;
    slot_ok   = 32'(cur.process_slot) < MAX_PROCESSES;
    idx       = SLOT_W'(cur.process_slot);
    base      = MADDR_W'(idx) * MADDR_W'(MAX_PAGES);
    cur_count = page_counts[idx];
    ptr_idx   = ptr[FR_W-1:0];
    ptr_free  = (ptr < live) && !frame_used[ptr_idx];
    too_big   = 32'(div_rsp.quotient) > MAX_PAGES;
    grows     = 32'(div_rsp.quotient) > 32'(cur_count);
    no_room   = 32'(div_rsp.quotient) > 32'(cur_count) + 32'(free_total);
    out_free  = !rsp_valid || rsp_ready;
  end

  assign req_ready = (state == S_IDLE) && !recount_pending;

  // divider launch
  always_comb begin
    div_req.start    = (state == S_DECODE) && slot_ok && slot_valid[idx]
                       && (cur.mode == MODE_RESIZE) && (cur.byte_size != '0);
    div_req.dividend = DIVIDEND_W'(cur.byte_size) + DIVIDEND_W'(eff_ps)
                       - DIVIDEND_W'(1);
    div_req.divisor  = eff_ps;
  end

  // memory port selection
  always_comb begin
    mem_we    = (state == S_GROW) && (have != need) && ptr_free;
    mem_waddr = base + MADDR_W'(have);
    if (state == S_DECODE) begin
      mem_raddr = base + MADDR_W'(PG_W'(cur.page_number));
    end else begin
      mem_raddr = base + MADDR_W'(have) - MADDR_W'(1);
    end
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_frames[mem_waddr] <= ptr_idx;
    end
    mem_rdata <= page_frames[mem_raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (recount_pending) begin
          state_next = S_RECOUNT;
        end else if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_RECOUNT: begin
        if (32'(ptr) == MAX_FRAMES - 1) begin
          state_next = S_IDLE;
        end
      end
      S_DECODE: begin
        if (div_req.start) begin
          state_next = S_DIV;
        end else if (slot_ok && slot_valid[idx] && (cur.mode == MODE_FINISH)) begin
          state_next = S_SHRINK_RD;
        end else if (slot_ok && slot_valid[idx] && (cur.mode == MODE_XLATE)
                     && (32'(cur.page_number) < 32'(cur_count))) begin
          state_next = S_XLATE_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (too_big || no_room) begin
            state_next = S_DONE;
          end else if (grows) begin
            state_next = S_GROW;
          end else begin
            state_next = S_SHRINK_RD;
          end
        end
      end
      S_GROW: begin
        if (have == need) begin
          state_next = S_DONE;
        end
      end
      S_SHRINK_RD: begin
        if (have == need) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHRINK_CLR;
        end
      end
      S_SHRINK_CLR: state_next = S_SHRINK_RD;
      S_XLATE_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // allocator state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_used      <= '0;
      slot_valid      <= '0;
      free_total      <= FCNT_W'(RESET_LIVE);
      recount_pending <= 1'b0;
      rsp_valid       <= 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        page_counts[i] <= '0;
      end
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          ptr <= '0;
          cnt <= '0;
          if (recount_pending) begin
            recount_pending <= 1'b0;
          end else if (req_valid) begin
            cur <= req;
          end
        end
        S_RECOUNT: begin
          // count clear bits below the live frame count
          ptr <= ptr + 1'b1;
          if (32'(ptr) == MAX_FRAMES - 1) begin
            free_total <= cnt + FCNT_W'(ptr_free);
          end else begin
            cnt <= cnt + FCNT_W'(ptr_free);
          end
        end
        S_DECODE: begin
          status <= ST_OK;
          frame  <= '0;
          have   <= cur_count;
          need   <= '0;
          if (!slot_ok) begin
            status <= ST_UNKNOWN;
          end else if (cur.mode == MODE_CREATE) begin
            if (slot_valid[idx]) begin
              status <= ST_EXISTS;
            end else begin
              slot_valid[idx]  <= 1'b1;
              page_counts[idx] <= '0;
            end
          end else if (!slot_valid[idx]) begin
            status <= ST_UNKNOWN;
          end else if ((cur.mode == MODE_XLATE)
                       && (32'(cur.page_number) >= 32'(cur_count))) begin
            status <= ST_RANGE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            need <= CNT_W'(div_rsp.quotient);
            if (too_big || no_room) begin
              status <= ST_OOM;
            end
          end
        end
        S_GROW: begin
          // take the lowest free frames in order
          if (have == need) begin
            page_counts[idx] <= have;
          end else begin
            ptr <= ptr + 1'b1;
            if (ptr_free) begin
              frame_used[ptr_idx] <= 1'b1;
              free_total          <= free_total - 1'b1;
              have                <= have + 1'b1;
            end
          end
        end
        S_SHRINK_RD: begin
          // release pages from the top
          if (have == need) begin
            page_counts[idx] <= have;
            if (cur.mode == MODE_FINISH) begin
              slot_valid[idx] <= 1'b0;
            end
          end else begin
            have <= have - 1'b1;
          end
        end
        S_SHRINK_CLR: begin
          frame_used[mem_rdata] <= 1'b0;
          if (FCNT_W'(mem_rdata) < live) begin
            free_total <= free_total + 1'b1;
          end
        end
        S_XLATE_WAIT: frame <= mem_rdata;
        S_DONE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      if (cfg_write && (paddr[2] == REG_FRAME_COUNT)) begin
        recount_pending <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      rsp.status      <= status;
      rsp.frame       <= 6'(frame);
      rsp.page_total  <= (slot_ok && slot_valid[idx]) ? 7'(cur_count) : 7'd0;
      rsp.frames_free <= 7'(free_total);
    end
  end

endmodule

/* sv/pfa_checker.sv */
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks for the paged frame allocator
// Watches the request and response channels and the response contents.
// ----------------------------------------------------------------------------
module pfa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pfa_pkg::rsp_t rsp
);
  import pfa_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // an accepted request leaves the block busy, with req_ready low, in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted on back-to-back cycles");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_EXISTS)
    else $error("undefined status code");

  // a failed request reports no frame
  a_frame_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.frame == 6'd0)
    else $error("frame reported on failed request");

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

/* test/paged_frame_allocator_test.sv */
// ----------------------------------------------------------------------------
// paged_frame_allocator_test: self-checking bench for the frame allocator
// Drives create, resize, translate and finish requests under random stalls,
// predicts every response with a behavioral model of the bitmap and page
// tables, and reconfigures page size and frame count between phases.
// ----------------------------------------------------------------------------
module paged_frame_allocator_test;
  import pfa_pkg::*;

  class alloc_scoreboard;
    localparam int NFRAMES = 64;
    localparam int NSLOTS  = 16;
    localparam int NPAGES  = 64;

    bit [12:0] page_size;
    bit [6:0]  frame_count;
    bit        frame_used [NFRAMES];
    bit [5:0]  page_map [NSLOTS][NPAGES];
    int        page_cnt [NSLOTS];
    bit        slot_open [NSLOTS];
    int        free_frames;
    rsp_t      expected_rsp [$];
    int        mismatches;

    function new();
      page_size   = 13'd32;
      frame_count = 7'd64;
      foreach (frame_used[i]) frame_used[i] = 1'b0;
      foreach (page_cnt[i]) begin
        page_cnt[i]  = 0;
        slot_open[i] = 1'b0;
      end
      mismatches = 0;
      recount();
    endfunction

    function int live_frames();
      return (frame_count > NFRAMES) ? NFRAMES : int'(frame_count);
    endfunction

    function void recount();
      free_frames = 0;
      for (int i = 0; i < live_frames(); i++)
        if (!frame_used[i]) free_frames++;
    endfunction

    function int lowest_free();
      for (int i = 0; i < live_frames(); i++)
        if (!frame_used[i]) return i;
      return 0;
    endfunction

    function void write_reg(logic idx, bit [31:0] value);
      if (idx == REG_PAGE_SIZE) begin
        page_size = value[12:0];
      end else begin
        frame_count = value[6:0];
        recount();
      end
    endfunction

    function logic [2:0] resize(int s, int bytes);
      int ps, need, have, f;
      ps = (page_size == 0) ? 1 : int'(page_size);
      if (bytes == 0) return ST_OK;
      need = (bytes + ps - 1) / ps;
      if (need > NPAGES) return ST_OOM;
      have = page_cnt[s];
      if (need > have) begin
        if (need - have > free_frames) return ST_OOM;
        while (have < need) begin
          f = lowest_free();
          frame_used[f] = 1'b1;
          page_map[s][have] = f[5:0];
          have++;
        end
      end else begin
        // free pages from the top of the table
        while (have > need) begin
          have--;
          frame_used[page_map[s][have]] = 1'b0;
        end
      end
      page_cnt[s] = have;
      recount();
      return ST_OK;
    endfunction

    // Compute the response of an accepted request and queue it
    function void note_request(req_t r);
      rsp_t e;
      int   s;
      s = r.process_slot;
      e = '0;
      if (r.mode == MODE_CREATE) begin
        if (slot_open[s]) e.status = ST_EXISTS;
        else begin
          slot_open[s] = 1'b1;
          page_cnt[s]  = 0;
        end
      end else if (!slot_open[s]) begin
        e.status = ST_UNKNOWN;
      end else if (r.mode == MODE_RESIZE) begin
        e.status = resize(s, r.byte_size);
      end else if (r.mode == MODE_XLATE) begin
        if (r.page_number >= page_cnt[s]) e.status = ST_RANGE;
        else e.frame = page_map[s][r.page_number];
      end else begin
        for (int i = 0; i < page_cnt[s]; i++) frame_used[page_map[s][i]] = 1'b0;
        page_cnt[s]  = 0;
        slot_open[s] = 1'b0;
        recount();
      end
      if (slot_open[s]) e.page_total = page_cnt[s][6:0];
      e.frames_free = free_frames[6:0];
      expected_rsp.push_back(e);
    endfunction

    // Compare a response transfer with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      e = expected_rsp.pop_front();
      if (got.status !== e.status || got.frame !== e.frame ||
          got.page_total !== e.page_total || got.frames_free !== e.frames_free) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"response mismatch: expected st=%0d fr=%0d pg=%0d free=%0d,",
                    " got st=%0d fr=%0d pg=%0d free=%0d"},
                   e.status, e.frame, e.page_total, e.frames_free,
                   got.status, got.frame, got.page_total, got.frames_free);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 120;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  req_t          req;
  logic          rsp_valid;
  logic          rsp_ready;
  rsp_t          rsp;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  alloc_scoreboard sb;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  int  hold_left;
  int  quiet_cycles;
  bit  apb_done;

  paged_frame_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check every response transfer
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // Drive rsp_ready: random stalls plus an occasional long hold-off
  initial begin
    rsp_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || apb_done || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one request, holding it until the transfer
  task automatic send_request(req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    forever begin
      @(posedge clk);
      if (req_ready) break;
    end
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid = 1'b0;
    while (sb.expected_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(logic idx, bit [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    apb_done <= 1'b1;
    sb.write_reg(idx, value);
    @(negedge clk);
    apb_done <= 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic req_t make_request(bit [1:0] m, bit [3:0] s, bit [18:0] b,
                                        bit [5:0] p);
    req_t r;
    r.mode = m;
    r.process_slot = s;
    r.byte_size = b;
    r.page_number = p;
    return r;
  endfunction

  // Random request, mostly sized to land near real page counts
  function automatic req_t random_request();
    int        sel, ps, pages;
    bit [18:0] bytes;
    bit [1:0]  m;
    sel = $urandom_range(99);
    if (sel < 15)      m = MODE_CREATE;
    else if (sel < 50) m = MODE_RESIZE;
    else if (sel < 87) m = MODE_XLATE;
    else               m = MODE_FINISH;
    ps = (sb.page_size == 0) ? 1 : int'(sb.page_size);
    sel = $urandom_range(99);
    if (sel < 70) begin
      pages = ($urandom_range(9) == 0) ? $urandom_range(66) : $urandom_range(12);
      bytes = 19'(pages * ps - $urandom_range(ps - 1));
      if (pages == 0) bytes = '0;
    end else if (sel < 80) begin
      bytes = '0;
    end else begin
      bytes = 19'($urandom);
    end
    return make_request(m, 4'($urandom_range(15)), bytes, 6'($urandom_range(63)));
  endfunction

  task automatic run_phase(int page_size, int frame_count, int n, int tx, int rx,
                           bit long_hold, bit mid_pause);
    wait_drained();
    apb_write(REG_PAGE_SIZE, page_size);
    apb_write(REG_FRAME_COUNT, frame_count);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 3) hold_req = 1'b1;
      if (mid_pause && i == n / 2) wait_drained();
      send_request(random_request());
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    apb_done = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    tx_idle_pct = 36;
    rx_idle_pct = 61;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: closed slot, duplicate create, zero size, limits, range
    send_request(make_request(MODE_XLATE, 0, 0, 0));
    send_request(make_request(MODE_RESIZE, 0, 64, 0));
    send_request(make_request(MODE_FINISH, 0, 0, 0));
    send_request(make_request(MODE_CREATE, 0, 0, 0));
    send_request(make_request(MODE_CREATE, 0, 0, 0));
    send_request(make_request(MODE_RESIZE, 0, 0, 0));
    send_request(make_request(MODE_RESIZE, 0, 1, 0));
    send_request(make_request(MODE_RESIZE, 0, 2048, 0));
    send_request(make_request(MODE_XLATE, 0, 0, 63));
    send_request(make_request(MODE_XLATE, 0, 0, 0));
    send_request(make_request(MODE_CREATE, 1, 0, 0));
    send_request(make_request(MODE_RESIZE, 1, 32, 0));
    send_request(make_request(MODE_RESIZE, 0, 2049, 0));
    send_request(make_request(MODE_RESIZE, 0, 100, 0));
    send_request(make_request(MODE_XLATE, 0, 0, 4));
    send_request(make_request(MODE_RESIZE, 1, 19'h7FFFF, 0));
    send_request(make_request(MODE_RESIZE, 1, 33, 0));
    send_request(make_request(MODE_XLATE, 1, 0, 1));
    send_request(make_request(MODE_FINISH, 0, 0, 0));
    send_request(make_request(MODE_CREATE, 15, 0, 0));
    send_request(make_request(MODE_RESIZE, 15, 19'h7FFFF, 63));
    send_request(make_request(MODE_XLATE, 15, 0, 63));
    send_request(make_request(MODE_FINISH, 15, 0, 0));

    // receiver idles more, then sender, then neither
    run_phase(32,   64,  125, 36, 61, 1'b1, 1'b0);
    run_phase(0,    127, 125, 36, 61, 1'b0, 1'b0);
    run_phase(4096, 20,  125, 61, 36, 1'b0, 1'b1);
    run_phase(1,    0,   100, 61, 36, 1'b0, 1'b0);
    run_phase(7,    64,  125, 0,  0,  1'b1, 1'b0);
    run_phase(32,   1,   125, 0,  0,  1'b0, 1'b0);

    wait_drained();
    if (sb.mismatches == 0 && sb.expected_rsp.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
